FILE: design/scfe_pkg.sv
// Shared types, line codes and CRC-16 helpers for the stuffed CRC-16 frame encoder.
// Used by the front, queue and back modules; depends on nothing else.
`default_nettype none
package scfe_pkg;

    localparam logic [7:0]  FLAG_CODE = 8'h7E;
    localparam logic [7:0]  ESC_CODE  = 8'h7D;
    localparam logic [7:0]  ESC_XOR   = 8'h20;
    localparam logic [15:0] CRC_POLY  = 16'h1021;

    typedef struct packed {
        logic [7:0]  data;
        logic        first;
        logic        last;
        logic [15:0] crc;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_OPEN   = 6'b000010,
        PH_DATA   = 6'b000100,
        PH_CRC_LO = 6'b001000,
        PH_CRC_HI = 6'b010000,
        PH_CLOSE  = 6'b100000
    } phase_t;

    function automatic logic [15:0] crc_table_entry(input logic [7:0] high);
        logic [15:0] t;
        t = {high, 8'h00};
        for (int k = 0; k < 8; k++) begin
            t = t[15] ? ((t << 1) ^ CRC_POLY) : (t << 1);
        end
        return t;
    endfunction

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        return crc_table_entry(crc[15:8]) ^ {crc[7:0], 8'h00} ^ {8'h00, b};
    endfunction

endpackage
`default_nettype wire

FILE: design/scfe_front.sv
// Front end of the stuffed CRC-16 frame encoder: accepts raw bytes, tracks the
// open frame, runs the CRC and queues one command per kept byte. Uses scfe_pkg.
`default_nettype none
module scfe_front (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,
    input  wire logic                  s_tlast,
    input  wire logic                  s_tuser,
    input  wire scfe_pkg::queue_status_t q_status,
    output logic                       push,
    output scfe_pkg::cmd_t             push_cmd
);

    logic        in_frame_reg;
    logic        in_frame_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic        accept;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        in_frame_next = in_frame_reg;
        crc_next      = crc_reg;
        push          = 1'b0;
        if (accept && (s_tuser || in_frame_reg)) begin
            push          = 1'b1;
            crc_next      = scfe_pkg::crc_update(s_tuser ? 16'h0000 : crc_reg, s_tdata);
            in_frame_next = !s_tlast;
        end
        push_cmd.data  = s_tdata;
        push_cmd.first = s_tuser;
        push_cmd.last  = s_tlast;
        push_cmd.crc   = crc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            crc_reg      <= 16'h0000;
        end else begin
            in_frame_reg <= in_frame_next;
            crc_reg      <= crc_next;
        end
    end

endmodule
`default_nettype wire

FILE: design/scfe_queue.sv
// Small command queue between the front and back of the frame encoder.
// Holds scfe_pkg::cmd_t entries; depends on scfe_pkg.
`default_nettype none
module scfe_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire scfe_pkg::cmd_t        push_cmd,
    input  wire logic                  pop,
    output scfe_pkg::cmd_t             pop_cmd,
    output scfe_pkg::queue_status_t    status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    scfe_pkg::cmd_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_cmd      = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

FILE: design/scfe_back.sv
// Back end of the frame encoder: walks each queued command through its line bytes
// (opening flag on a first byte, stuffed data, and on a last byte the stuffed CRC and
// closing flag) into an output register. Depends on scfe_pkg.
`default_nettype none
module scfe_back (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire scfe_pkg::cmd_t        pop_cmd,
    input  wire scfe_pkg::queue_status_t q_status,
    output logic                       pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [7:0]                 m_tdata,
    output logic                       m_tlast,
    output logic                       m_tuser
);

    scfe_pkg::phase_t phase_reg;
    scfe_pkg::phase_t phase_next;
    scfe_pkg::phase_t step_phase;
    scfe_pkg::cmd_t   cmd_reg;
    scfe_pkg::cmd_t   cmd_next;
    logic             esc_reg;
    logic             esc_next;
    logic             m_tvalid_reg;
    logic             m_tvalid_next;
    logic [7:0]       m_tdata_reg;
    logic [7:0]       m_tdata_next;
    logic             m_tlast_reg;
    logic             m_tlast_next;
    logic             m_tuser_reg;
    logic             m_tuser_next;
    logic             advance;
    logic [7:0]       cur_byte;
    logic             stuffable;
    logic             done;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;
    assign advance  = !m_tvalid_reg || m_tready;

    always_comb begin
        cur_byte   = scfe_pkg::FLAG_CODE;
        stuffable  = 1'b0;
        done       = 1'b0;
        step_phase = scfe_pkg::PH_IDLE;
        unique case (phase_reg)
            scfe_pkg::PH_OPEN: begin
                step_phase = scfe_pkg::PH_DATA;
            end
            scfe_pkg::PH_DATA: begin
                cur_byte  = cmd_reg.data;
                stuffable = 1'b1;
                done      = !cmd_reg.last;
                step_phase = cmd_reg.last ? scfe_pkg::PH_CRC_LO : scfe_pkg::PH_IDLE;
            end
            scfe_pkg::PH_CRC_LO: begin
                cur_byte   = cmd_reg.crc[7:0];
                stuffable  = 1'b1;
                step_phase = scfe_pkg::PH_CRC_HI;
            end
            scfe_pkg::PH_CRC_HI: begin
                cur_byte   = cmd_reg.crc[15:8];
                stuffable  = 1'b1;
                step_phase = scfe_pkg::PH_CLOSE;
            end
            scfe_pkg::PH_CLOSE: begin
                done = 1'b1;
            end
            default: begin
                step_phase = scfe_pkg::PH_IDLE;
            end
        endcase
    end

    always_comb begin
        phase_next    = phase_reg;
        cmd_next      = cmd_reg;
        esc_next      = esc_reg;
        pop           = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;
        unique case (phase_reg)
            scfe_pkg::PH_IDLE: begin
                if (!q_status.empty) begin
                    pop        = 1'b1;
                    cmd_next   = pop_cmd;
                    phase_next = pop_cmd.first ? scfe_pkg::PH_OPEN : scfe_pkg::PH_DATA;
                end
            end
            scfe_pkg::PH_OPEN, scfe_pkg::PH_DATA, scfe_pkg::PH_CRC_LO,
            scfe_pkg::PH_CRC_HI, scfe_pkg::PH_CLOSE: begin
                if (advance) begin
                    m_tvalid_next = 1'b1;
                    if (stuffable && !esc_reg &&
                        (cur_byte == scfe_pkg::FLAG_CODE || cur_byte == scfe_pkg::ESC_CODE)) begin
                        m_tdata_next = scfe_pkg::ESC_CODE;
                        m_tlast_next = 1'b0;
                        m_tuser_next = 1'b0;
                        esc_next     = 1'b1;
                    end else begin
                        m_tdata_next = esc_reg ? (cur_byte ^ scfe_pkg::ESC_XOR) : cur_byte;
                        m_tlast_next = (phase_reg == scfe_pkg::PH_CLOSE);
                        m_tuser_next = done;
                        esc_next     = 1'b0;
                        phase_next   = step_phase;
                        if (done) begin
                            phase_next = scfe_pkg::PH_IDLE;
                            if (!q_status.empty) begin
                                pop        = 1'b1;
                                cmd_next   = pop_cmd;
                                phase_next = pop_cmd.first ? scfe_pkg::PH_OPEN
                                                           : scfe_pkg::PH_DATA;
                            end
                        end
                    end
                end
            end
            default: begin
                phase_next = scfe_pkg::PH_IDLE;
                esc_next   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        m_tdata_reg  <= m_tdata_next;
        m_tlast_reg  <= m_tlast_next;
        m_tuser_reg  <= m_tuser_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= scfe_pkg::PH_IDLE;
            esc_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            esc_reg      <= esc_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule
`default_nettype wire

FILE: design/stuffed_crc16_frame_encoder_top.sv
// Top level of the stuffed CRC-16 frame encoder: front, command queue and back.
// Depends on scfe_pkg, scfe_front, scfe_queue and scfe_back.
// Path: with the back end idle, an accepted raw byte passes the queue, the back
// end's command register and the output register before its first line byte
// shows. Throughput: the back end emits one line byte per cycle while m_tready
// holds; the queue of QUEUE_DEPTH commands absorbs the bursts.
// Reset: synchronous on aresetn low; clears the open-frame mark, CRC, queue, back-end phase and output valid.
`default_nettype none
module stuffed_crc16_frame_encoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       s_tlast,
    input  wire logic       s_tuser,   // [0] frame_first
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tlast,
    output logic            m_tuser    // [0] run_last
);

    scfe_pkg::queue_status_t q_status;
    scfe_pkg::cmd_t          push_cmd;
    scfe_pkg::cmd_t          pop_cmd;
    logic                    push;
    logic                    pop;

    scfe_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    scfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .status   (q_status)
    );

    scfe_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pop_cmd  (pop_cmd),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

FILE: design/scfe_checker.sv
// Port-level checks for the stuffed CRC-16 frame encoder and the bind that
// attaches them to stuffed_crc16_frame_encoder_top.
`default_nettype none
module scfe_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast,
    input wire logic       m_tuser
);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result channel valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result item dropped or changed");

    a_close_is_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata == scfe_pkg::FLAG_CODE && m_tuser)
        else $error("closing item is not a flag ending its run");

    a_escape_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata == scfe_pkg::ESC_CODE |-> !m_tuser && !m_tlast)
        else $error("escape code ends a run");

endmodule

bind stuffed_crc16_frame_encoder_top scfe_checker u_scfe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
`default_nettype wire
